### rtl/plp_pkg.sv
`default_nettype none

package plp_pkg;

    // Storage size and the derived widths.
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 8;
    localparam int EFF_CAP  = (CAPACITY < 255) ? CAPACITY : 255;
    localparam logic [CNT_W:0] EFF_CAP_V = (CNT_W + 1)'(EFF_CAP);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_MOVE = 1'b1
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [CNT_W-1:0]   position;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
        logic [CNT_W-1:0]   count;
    } t_result;

    // Converts an 8-bit list index into a memory address of any width.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [CNT_W-1:0] x);
        logic [ADDR_W+CNT_W-1:0] w;
        w = {{ADDR_W{1'b0}}, x};
        return w[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/plp_ram.sv
`default_nettype none

module plp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/positional_list_insert_delete.sv
// Positional list of up to CAPACITY signed 32-bit words (at most 255), held in one
// single-port-read, single-port-write memory. An item is accepted when start is high
// and busy is low; its one result appears on o_result for exactly one cycle with
// o_valid high and cannot be held off. Clear, rejected requests and inserts at the
// end of the list finish at once: the result shows in the cycle after acceptance.
// Any other item reads m words and writes back the ones it shifts, one read and one
// write per cycle (m = count - position + 1 for insert and delete, m = 1 for read).
// It holds busy while the words move, and its result shows in the cycle in which
// busy falls. The worst case is a delete at position 1 of a full list. Words read
// from entries past the count are never used, so the memory needs no clearing
// after reset.
`default_nettype none

module positional_list_insert_delete (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire plp_pkg::t_item  i_item,
    output logic                 o_valid,
    output plp_pkg::t_result     o_result
);

    localparam int AW = plp_pkg::ADDR_W;
    localparam int CW = plp_pkg::CNT_W;

    plp_pkg::t_state    r_state, n_state;
    plp_pkg::t_op       r_op, n_op;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic [AW-1:0]      r_raddr, n_raddr;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [AW-1:0]      r_pos, n_pos;
    logic               r_pend, n_pend;
    logic               r_first, n_first;
    logic signed [31:0] r_value, n_value;
    logic signed [31:0] r_data, n_data;
    logic               r_valid, n_valid;
    plp_pkg::t_result   r_result, n_result;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    logic               accept;
    logic [CW-1:0]      idx;
    logic               ins_bad;
    logic               acc_bad;

    plp_ram #(
        .WIDTH (32),
        .DEPTH (plp_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != plp_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Position checks on the incoming beat.
    assign idx     = i_item.position - CW'(1);
    assign ins_bad = (i_item.position == '0) ||
                     ({1'b0, i_item.position} > ({1'b0, r_count} + (CW + 1)'(1)));
    assign acc_bad = (i_item.position == '0) || (i_item.position > r_count);

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plp_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_first <= 1'b0;
            r_op    <= plp_pkg::OP_INSERT;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_left  <= n_left;
            r_first <= n_first;
            r_op    <= n_op;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_raddr  <= n_raddr;
        r_waddr  <= n_waddr;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_data   <= n_data;
        r_result <= n_result;
    end

    // Next state, memory control and result.
    // Reads and writes of a shift always touch addresses two apart, so the
    // registered read needs no forwarding.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_count  = r_count;
        n_left   = r_left;
        n_raddr  = r_raddr;
        n_waddr  = r_waddr;
        n_pos    = r_pos;
        n_pend   = 1'b0;
        n_first  = r_first;
        n_value  = r_value;
        n_data   = r_data;
        n_valid  = 1'b0;
        n_result = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = r_value;

        case (r_state)
            plp_pkg::S_IDLE: begin
                if (accept) begin
                    n_op              = i_item.op;
                    n_result.status   = plp_pkg::ST_OK;
                    n_result.data_out = '0;
                    n_result.count    = r_count;
                    n_pos             = plp_pkg::to_addr(idx);
                    n_value           = i_item.value;
                    case (i_item.op)
                        plp_pkg::OP_INSERT: begin
                            if (ins_bad) begin
                                n_result.status = plp_pkg::ST_BAD_POS;
                                n_valid         = 1'b1;
                            end else if ({1'b0, r_count} >= plp_pkg::EFF_CAP_V) begin
                                n_result.status = plp_pkg::ST_FULL;
                                n_valid         = 1'b1;
                            end else if (idx == r_count) begin
                                // Append: nothing moves, write the word now.
                                ram_we          = 1'b1;
                                ram_waddr       = plp_pkg::to_addr(idx);
                                ram_wdata       = i_item.value;
                                n_count         = r_count + CW'(1);
                                n_result.count  = n_count;
                                n_valid         = 1'b1;
                            end else begin
                                n_state = plp_pkg::S_MOVE;
                                n_raddr = plp_pkg::to_addr(r_count - CW'(1));
                                n_waddr = plp_pkg::to_addr(r_count);
                                n_left  = r_count - idx;
                                n_first = 1'b0;
                            end
                        end
                        plp_pkg::OP_DELETE, plp_pkg::OP_READ: begin
                            if (acc_bad) begin
                                n_result.status = plp_pkg::ST_BAD_POS;
                                n_valid         = 1'b1;
                            end else begin
                                n_state = plp_pkg::S_MOVE;
                                n_raddr = plp_pkg::to_addr(idx);
                                n_waddr = plp_pkg::to_addr(idx);
                                n_left  = (i_item.op == plp_pkg::OP_DELETE) ?
                                          (r_count - idx) : CW'(1);
                                n_first = 1'b1;
                            end
                        end
                        plp_pkg::OP_CLEAR: begin
                            n_count        = '0;
                            n_result.count = '0;
                            n_valid        = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            plp_pkg::S_MOVE: begin
                // Land the word read in the previous cycle.
                if (r_pend) begin
                    if (r_first) begin
                        n_data  = ram_rdata;
                        n_first = 1'b0;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_waddr;
                        ram_wdata = ram_rdata;
                        n_waddr   = (r_op == plp_pkg::OP_INSERT) ?
                                    (r_waddr - AW'(1)) : (r_waddr + AW'(1));
                    end
                end

                // Issue the next read.
                if (r_left != '0) begin
                    n_raddr = (r_op == plp_pkg::OP_INSERT) ?
                              (r_raddr - AW'(1)) : (r_raddr + AW'(1));
                    n_left  = r_left - CW'(1);
                    n_pend  = 1'b1;
                end

                // All words moved: finish the item.
                if ((r_left == '0) && !r_pend) begin
                    n_state           = plp_pkg::S_IDLE;
                    n_valid           = 1'b1;
                    n_result.status   = plp_pkg::ST_OK;
                    n_result.data_out = (r_op == plp_pkg::OP_INSERT) ? 32'sd0 : r_data;
                    case (r_op)
                        plp_pkg::OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pos;
                            ram_wdata = r_value;
                            n_count   = r_count + CW'(1);
                        end
                        plp_pkg::OP_DELETE: begin
                            n_count = r_count - CW'(1);
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                    n_result.count = n_count;
                end
            end

            default: begin
                n_state = plp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/plp_chk.sv
`default_nettype none

module plp_chk (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire plp_pkg::t_item   i_item,
    input wire logic             o_valid,
    input wire plp_pkg::t_result o_result
);

    // An accepted beat either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted beat neither answered nor in progress");

    // Clear answers in the next cycle with an empty list.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == plp_pkg::OP_CLEAR)) |=>
        (o_valid && (o_result.count == '0) && (o_result.status == plp_pkg::ST_OK)))
        else $error("clear did not report an empty list");

    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_result.count} <= plp_pkg::EFF_CAP_V))
        else $error("length beyond capacity");

    // A rejected request returns no data.
    a_reject_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != plp_pkg::ST_OK)) |-> (o_result.data_out == '0))
        else $error("rejected request returned data");

    // A full report comes only from a full list.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == plp_pkg::ST_FULL)) |->
        ({1'b0, o_result.count} == plp_pkg::EFF_CAP_V))
        else $error("full status on a list that is not full");

endmodule

bind positional_list_insert_delete plp_chk u_plp_chk (.*);

`default_nettype wire
